// ----- rtl/act_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and codes of the access control table.
package act_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned MODE_WIDTH  = 3;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_GET      = 3'd1,
    ACT_DEL_RES  = 3'd2,
    ACT_DEL_CLI  = 3'd3,
    ACT_SET_RES  = 3'd4,
    ACT_SET_PAIR = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]           action;
    logic [KEY_WIDTH-1:0] resource_key;
    logic [KEY_WIDTH-1:0] client_key;
    logic [2:0]           mode_in;
  } act_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] mode_out;
  } act_out_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]  resource;
    logic [KEY_WIDTH-1:0]  client;
    logic [MODE_WIDTH-1:0] mode;
  } entry_t;

  typedef struct packed {
    logic res_hit;
    logic cli_hit;
  } match_t;

endpackage

// ----- rtl/access_control_table_core.sv -----
`timescale 1ns / 1ps
// Access control table: a small sequencer walks one entry RAM through a shared compare unit.
//
// The block keeps up to TABLE_DEPTH (resource, client, mode) entries in insertion order in a
// single RAM and serves one request word at a time. An add writes its entry in the start
// state and then answers from the response state. Every other action walks the stored
// entries one per cycle through a single key compare unit, because the RAM gives one
// registered read each cycle, and a get or pair update stops early at the first match.
// Removals compact the table in the same pass: survivors are written back at a lagging
// write pointer while the read pointer runs ahead, so their order is kept. The input is
// ready only while the sequencer is idle; the result sits in an output register, so a new
// request word may be taken while the previous answer still waits for the consumer.
// Stored entries need no clearing after reset, as only data from slots below the entry
// count is ever used.
module access_control_table_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  act_pkg::act_in_t in_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output act_pkg::act_out_t out_word_o
);

  localparam int unsigned IW = act_pkg::IDX_W;
  localparam int unsigned CW = act_pkg::CNT_W;
  localparam int unsigned MW = act_pkg::MODE_WIDTH;

  act_pkg::state_e   state_q, state_d;
  act_pkg::act_in_t  req_q, req_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]     rd_q, rd_d;
  logic [IW-1:0]     wr_q, wr_d;
  logic              found_q, found_d;
  act_pkg::status_e  res_status_q, res_status_d;
  logic [2:0]        res_mode_q, res_mode_d;
  logic              out_valid_q, out_valid_d;
  act_pkg::act_out_t out_word_q, out_word_d;

  // RAM port and compare unit signals.
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  act_pkg::entry_t   ram_wdata;
  logic [IW-1:0]     ram_raddr;
  act_pkg::entry_t   ram_rdata;
  act_pkg::match_t   match;
  logic              hit;
  logic              last;

  act_ram #(
    .WIDTH ($bits(act_pkg::entry_t)),
    .DEPTH (act_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  act_match u_match (
    .entry_i        (ram_rdata),
    .resource_key_i (req_q.resource_key),
    .client_key_i   (req_q.client_key),
    .match_o        (match)
  );

  // Which comparison counts as a hit depends on the action being served.
  always_comb begin
    case (req_q.action)
      act_pkg::ACT_DEL_RES,
      act_pkg::ACT_SET_RES: hit = match.res_hit;
      act_pkg::ACT_DEL_CLI: hit = match.cli_hit;
      default:              hit = match.res_hit & match.cli_hit;
    endcase
  end

  // The entry just read is the last valid one.
  assign last = ((CW'(rd_q) + CW'(1)) == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= act_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    rd_q         <= rd_d;
    wr_q         <= wr_d;
    found_q      <= found_d;
    res_status_q <= res_status_d;
    res_mode_q   <= res_mode_d;
    out_word_q   <= out_word_d;
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    cnt_d        = cnt_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    found_d      = found_q;
    res_status_d = res_status_q;
    res_mode_d   = res_mode_q;
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    ram_we       = 1'b0;
    ram_waddr    = wr_q;
    ram_wdata    = ram_rdata;
    ram_raddr    = rd_q + IW'(1);
    in_ready_o   = 1'b0;

    // The consumer takes the waiting result word.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      act_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d   = in_word_i;
          rd_d    = '0;
          wr_d    = '0;
          found_d = 1'b0;
          state_d = act_pkg::S_START;
        end
      end

      act_pkg::S_START: begin
        // Present slot zero so the scan sees it in the next cycle.
        ram_raddr    = '0;
        res_status_d = act_pkg::ST_NOT_FOUND;
        res_mode_d   = '0;
        state_d      = act_pkg::S_RESP;
        case (req_q.action)
          act_pkg::ACT_ADD: begin
            if (cnt_q == CW'(act_pkg::TABLE_DEPTH)) begin
              res_status_d = act_pkg::ST_FULL;
            end else begin
              ram_we             = 1'b1;
              ram_waddr          = cnt_q[IW-1:0];
              ram_wdata.resource = req_q.resource_key;
              ram_wdata.client   = req_q.client_key;
              ram_wdata.mode     = MW'(req_q.mode_in);
              cnt_d              = cnt_q + CW'(1);
              res_status_d       = act_pkg::ST_OK;
            end
          end
          act_pkg::ACT_GET,
          act_pkg::ACT_DEL_RES,
          act_pkg::ACT_DEL_CLI,
          act_pkg::ACT_SET_RES,
          act_pkg::ACT_SET_PAIR: begin
            if (cnt_q != '0) begin
              state_d = act_pkg::S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end

      act_pkg::S_SCAN: begin
        // ram_rdata holds slot rd_q; slot rd_q + 1 is being read meanwhile.
        rd_d = rd_q + IW'(1);
        case (req_q.action)
          act_pkg::ACT_GET: begin
            if (hit) begin
              res_status_d = act_pkg::ST_OK;
              res_mode_d   = 3'(ram_rdata.mode);
              state_d      = act_pkg::S_RESP;
            end else if (last) begin
              state_d = act_pkg::S_RESP;
            end
          end
          act_pkg::ACT_SET_PAIR: begin
            if (hit) begin
              ram_we         = 1'b1;
              ram_waddr      = rd_q;
              ram_wdata.mode = MW'(req_q.mode_in);
              res_status_d   = act_pkg::ST_OK;
              state_d        = act_pkg::S_RESP;
            end else if (last) begin
              state_d = act_pkg::S_RESP;
            end
          end
          act_pkg::ACT_SET_RES: begin
            if (hit) begin
              ram_we         = 1'b1;
              ram_waddr      = rd_q;
              ram_wdata.mode = MW'(req_q.mode_in);
              found_d        = 1'b1;
            end
            if (last) begin
              if (hit || found_q) begin
                res_status_d = act_pkg::ST_OK;
              end
              state_d = act_pkg::S_RESP;
            end
          end
          default: begin
            // Removal: survivors move down to the write pointer in order.
            if (hit) begin
              found_d = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = wr_q;
              wr_d      = wr_q + IW'(1);
            end
            if (last) begin
              cnt_d = CW'(wr_q) + CW'(!hit);
              if (hit || found_q) begin
                res_status_d = act_pkg::ST_OK;
              end
              state_d = act_pkg::S_RESP;
            end
          end
        endcase
      end

      act_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_word_d.status   = res_status_q;
          out_word_d.mode_out = res_mode_q;
          state_d             = act_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = act_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // The entry count never passes the table depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(act_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // The scan only reads slots that hold valid entries.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == act_pkg::S_SCAN |-> CW'(rd_q) < cnt_q)
    else $error("scan pointer beyond entry count");

  // Compaction writes never overtake the read pointer.
  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == act_pkg::S_SCAN |-> wr_q <= rd_q)
    else $error("write pointer ahead of read pointer");

  // The entry count shrinks only at the end of a removal scan.
  a_cnt_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < $past(cnt_q) |-> $past(state_q) == act_pkg::S_SCAN)
    else $error("entry count dropped outside a scan");

  // A fresh result word is loaded only from the response state.
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == act_pkg::S_RESP)
    else $error("result raised outside the response state");

endmodule

// ----- rtl/act_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module act_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/act_match.sv -----
`timescale 1ns / 1ps
// Key compare unit: matches one stored entry against the requested keys.
module act_match (
  input  act_pkg::entry_t                  entry_i,
  input  logic [act_pkg::KEY_WIDTH-1:0]    resource_key_i,
  input  logic [act_pkg::KEY_WIDTH-1:0]    client_key_i,
  output act_pkg::match_t                  match_o
);

  always_comb begin
    match_o.res_hit = (entry_i.resource == resource_key_i);
    match_o.cli_hit = (entry_i.client == client_key_i);
  end

endmodule
